FILE: rtl/core/pli_pkg.sv
// Shared types and fixed field widths for the posting list intersection block.
// Used by pli_head_cmp and posting_list_intersection; depends on nothing.
package pli_pkg;

	// fixed widths of the stream fields
	localparam int DOC_ID_W   = 20;
	localparam int WEIGHT_W   = 16;
	localparam int LIST_IDX_W = 2;
	localparam int NUM_SLOTS  = 2 ** LIST_IDX_W;
	localparam int COUNT_W    = 3;
	localparam int S_TDATA_W  = 40;
	localparam int S_TUSER_W  = 3;
	localparam int M_TDATA_W  = 88;

	// head comparison outcome handed from the compare unit to the sequencer
	typedef struct packed {
		logic                  same;
		logic [LIST_IDX_W-1:0] best;
	} cmp_t;

endpackage

FILE: rtl/core/pli_head_cmp.sv
// Head compare unit: checks whether all list heads in use agree and finds the
// list holding the smallest head id (lowest list wins a tie). Uses pli_pkg.
module pli_head_cmp #(
	parameter int DOC_ID_BITS = 20
) (
	input  logic [DOC_ID_BITS-1:0]   head_id [pli_pkg::NUM_SLOTS],
	input  logic [pli_pkg::NUM_SLOTS-1:0] use_mask,
	output pli_pkg::cmp_t            cmp
);

	logic [DOC_ID_BITS-1:0] best_id;

	// equality against list 0 and running minimum over the other lists
	always_comb begin
		cmp.same = 1'b1;
		cmp.best = '0;
		best_id  = head_id[0];
		for (int i = 1; i < pli_pkg::NUM_SLOTS; i++) begin
			if (use_mask[i]) begin
				if (head_id[i] != head_id[0]) begin
					cmp.same = 1'b0;
				end
				if (head_id[i] < best_id) begin
					best_id  = head_id[i];
					cmp.best = pli_pkg::LIST_IDX_W'(i);
				end
			end
		end
	end

endmodule

FILE: rtl/core/posting_list_intersection.sv
// Posting list intersection: loads posting lists into one entry memory and
// runs a k-way merge over registered list heads. Uses pli_pkg, pli_head_cmp.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+--------------------------------------
//  cfg     | in  | cfg_we             | list_count
//  s       | in  | s_tvalid/s_tready  | list_index, doc_id, weight, last_entry
//  m       | out | m_tvalid/m_tready  | found, match_doc_id, weight_0..3, last
//
// Loading takes one beat per cycle. The beat with tlast starts the merge and
// input stalls until the final result is in the output register. Each merge
// step is a compare, then a read and a capture state per list head reloaded
// through the single memory read port (a read state alone for an exhausted
// list), then leaving the reload. A mismatch reloads the list with the smallest
// head, a match every list in use; the first heads are fetched the same way,
// and a last compare plus a finish state close the merge. Reset sets
// list_count to 1 and clears the fill counts; the entry memory is not cleared.
// A stalled output holds a further match in the compare state until it frees up.
module posting_list_intersection #(
	parameter int MAX_LISTS   = 4,
	parameter int LIST_DEPTH  = 64,
	parameter int DOC_ID_BITS = 20,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pli_pkg::COUNT_W-1:0]     cfg_wdata,  // list_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pli_pkg::S_TDATA_W-1:0]   s_tdata,    // doc_id[19:0], weight[35:20]
	input  logic [pli_pkg::S_TUSER_W-1:0]   s_tuser,    // list_index[1:0], entry_valid[2]
	input  logic                            s_tlast,    // last_entry
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pli_pkg::M_TDATA_W-1:0]   m_tdata,    // match_doc_id[19:0], weight_0..3
	output logic                            m_tuser,    // found
	output logic                            m_tlast     // last_result
);

	localparam int SLOTS   = MAX_LISTS * LIST_DEPTH;
	localparam int ADDR_W  = $clog2(SLOTS);
	localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
	localparam int ENTRY_W = DOC_ID_BITS + WEIGHT_BITS;
	localparam int NSL     = pli_pkg::NUM_SLOTS;
	localparam int LW      = pli_pkg::LIST_IDX_W;

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_REFILL = 3'd1;
	localparam logic [2:0] ST_CAPT   = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]                  state_q;
	logic [pli_pkg::COUNT_W-1:0] list_count_q;
	logic [FILL_W-1:0]           fill_q   [NSL];
	logic [FILL_W-1:0]           cursor_q [NSL];
	logic [NSL-1:0]              pend_q;
	logic [LW-1:0]               capt_list_q;
	logic [FILL_W-1:0]           match_cnt_q;
	logic [DOC_ID_BITS-1:0]      head_id_q [NSL];
	logic [WEIGHT_BITS-1:0]      head_wt_q [NSL];
	logic                        hold_v_q;
	logic [DOC_ID_BITS-1:0]      hold_id_q;
	logic [WEIGHT_BITS-1:0]      hold_wt_q [NSL];
	logic                        out_v_q;
	logic                        out_found_q;
	logic                        out_last_q;
	logic [pli_pkg::M_TDATA_W-1:0] out_data_q;

	logic [ENTRY_W-1:0]          mem [SLOTS];
	logic [ENTRY_W-1:0]          rd_data_q;

	// input beat decode
	logic [LW-1:0]          in_li;
	logic                   in_ev;
	logic [DOC_ID_BITS-1:0] in_id;
	logic [WEIGHT_BITS-1:0] in_wt;
	logic                   accept;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;

	assign in_li    = s_tuser[LW-1:0];
	assign in_ev    = s_tuser[LW];
	assign in_id    = DOC_ID_BITS'(s_tdata[pli_pkg::DOC_ID_W-1:0]);
	assign in_wt    = WEIGHT_BITS'(s_tdata[pli_pkg::DOC_ID_W +: pli_pkg::WEIGHT_W]);
	assign s_tready = (state_q == ST_LOAD);
	assign accept   = s_tvalid & s_tready;
	assign wr_en    = accept & in_ev & ({1'b0, in_li} < (LW + 1)'(MAX_LISTS))
	                  & (fill_q[in_li] < FILL_W'(LIST_DEPTH));
	assign wr_addr  = ADDR_W'(in_li) * ADDR_W'(LIST_DEPTH) + ADDR_W'(fill_q[in_li]);

	// lists in use, with out-of-range counts clamped
	logic [NSL-1:0] use_mask;
	logic [pli_pkg::COUNT_W-1:0] lists_n;

	always_comb begin
		lists_n = list_count_q;
		if (list_count_q == '0) begin
			lists_n = pli_pkg::COUNT_W'(1);
		end else if (list_count_q > pli_pkg::COUNT_W'(MAX_LISTS)) begin
			lists_n = pli_pkg::COUNT_W'(MAX_LISTS);
		end
		for (int i = 0; i < NSL; i++) begin
			use_mask[i] = (pli_pkg::COUNT_W'(i) < lists_n);
		end
	end

	// lowest list still waiting for a head reload
	logic [LW-1:0] ref_list;
	logic          ref_live;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		ref_list = '0;
		for (int i = NSL - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				ref_list = LW'(i);
			end
		end
		ref_live = (cursor_q[ref_list] < fill_q[ref_list]);
		rd_addr  = ADDR_W'(ref_list) * ADDR_W'(LIST_DEPTH) + ADDR_W'(cursor_q[ref_list]);
	end

	// exhaustion check over the lists in use
	logic exhausted;

	always_comb begin
		exhausted = 1'b0;
		for (int i = 0; i < NSL; i++) begin
			if (use_mask[i] && (cursor_q[i] >= fill_q[i])) begin
				exhausted = 1'b1;
			end
		end
	end

	pli_pkg::cmp_t cmp;

	pli_head_cmp #(
		.DOC_ID_BITS (DOC_ID_BITS)
	) u_head_cmp (
		.head_id  (head_id_q),
		.use_mask (use_mask),
		.cmp      (cmp)
	);

	logic out_free;
	assign out_free = !out_v_q || m_tready;

	// entry memory: one write port for loading, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_wt, in_id};
		end
		if (state_q == ST_REFILL) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// head and held-result payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CAPT) begin
			head_id_q[capt_list_q] <= rd_data_q[DOC_ID_BITS-1:0];
			head_wt_q[capt_list_q] <= rd_data_q[ENTRY_W-1:DOC_ID_BITS];
		end
		if ((state_q == ST_CHECK) && !exhausted && (match_cnt_q < FILL_W'(LIST_DEPTH))
		    && cmp.same && (!hold_v_q || out_free)) begin
			hold_id_q <= head_id_q[0];
			for (int i = 0; i < NSL; i++) begin
				hold_wt_q[i] <= use_mask[i] ? head_wt_q[i] : '0;
			end
		end
	end

	// output register payload
	logic                          push;
	logic                          push_found;
	logic                          push_last;
	logic [pli_pkg::M_TDATA_W-1:0] push_data;

	always_comb begin
		push       = 1'b0;
		push_found = 1'b0;
		push_last  = 1'b0;
		push_data  = '0;
		if ((state_q == ST_CHECK) && !exhausted && (match_cnt_q < FILL_W'(LIST_DEPTH))
		    && cmp.same && hold_v_q && out_free) begin
			push       = 1'b1;
			push_found = 1'b1;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			push       = 1'b1;
			push_found = hold_v_q;
			push_last  = 1'b1;
		end
		if (push_found) begin
			push_data[pli_pkg::DOC_ID_W-1:0] = pli_pkg::DOC_ID_W'(hold_id_q);
			for (int i = 0; i < NSL; i++) begin
				push_data[pli_pkg::DOC_ID_W + i*pli_pkg::WEIGHT_W +: pli_pkg::WEIGHT_W] =
					pli_pkg::WEIGHT_W'(hold_wt_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q  <= push_data;
			out_found_q <= push_found;
			out_last_q  <= push_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

	// merge sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			list_count_q <= pli_pkg::COUNT_W'(1);
			pend_q       <= '0;
			capt_list_q  <= '0;
			match_cnt_q  <= '0;
			hold_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
			for (int i = 0; i < NSL; i++) begin
				fill_q[i]   <= '0;
				cursor_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				list_count_q <= cfg_wdata;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (wr_en) begin
						fill_q[in_li] <= fill_q[in_li] + FILL_W'(1);
					end
					if (accept && s_tlast) begin
						pend_q  <= use_mask;
						state_q <= ST_REFILL;
					end
				end
				ST_REFILL: begin
					if (pend_q == '0) begin
						state_q <= ST_CHECK;
					end else if (ref_live) begin
						capt_list_q <= ref_list;
						state_q     <= ST_CAPT;
					end else begin
						pend_q[ref_list] <= 1'b0;
					end
				end
				ST_CAPT: begin
					pend_q[capt_list_q] <= 1'b0;
					state_q             <= ST_REFILL;
				end
				ST_CHECK: begin
					if (exhausted || (match_cnt_q >= FILL_W'(LIST_DEPTH))) begin
						state_q <= ST_FINISH;
					end else if (cmp.same) begin
						if (!hold_v_q || out_free) begin
							hold_v_q    <= 1'b1;
							match_cnt_q <= match_cnt_q + FILL_W'(1);
							for (int i = 0; i < NSL; i++) begin
								if (use_mask[i]) begin
									cursor_q[i] <= cursor_q[i] + FILL_W'(1);
								end
							end
							pend_q  <= use_mask;
							state_q <= ST_REFILL;
						end
					end else begin
						cursor_q[cmp.best] <= cursor_q[cmp.best] + FILL_W'(1);
						pend_q             <= NSL'(1) << cmp.best;
						state_q            <= ST_REFILL;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						hold_v_q    <= 1'b0;
						match_cnt_q <= '0;
						for (int i = 0; i < NSL; i++) begin
							fill_q[i]   <= '0;
							cursor_q[i] <= '0;
						end
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
